// ----- rtl/core/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list store
// Request and response words, request and status codes, per-cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int CAPACITY    = 256;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 8;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP_SIZE  = 16;
  localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_POS  = 3'd0,
    REQ_INS_HEAD = 3'd1,
    REQ_INS_TAIL = 3'd2,
    REQ_REM_POS  = 3'd3,
    REQ_REM_HEAD = 3'd4,
    REQ_REM_TAIL = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MERGE
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]      removed_data;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count_after;
  } rsp_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              pick;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/pls_cell.sv -----
// ----------------------------------------------------------------------------
// pls_cell: one entry of the list chain
// Holds one word; takes its left neighbor on insert, its right neighbor on
// removal, and offers its word on the pick bus when it is the removed one.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_cell (
  input  wire logic                      clk_i,
  input  wire pls_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [pls_pkg::IDX_W-1:0] index_i,
  input  wire logic [pls_pkg::DATA_W-1:0] left_i,
  input  wire logic [pls_pkg::DATA_W-1:0] right_i,
  output logic [pls_pkg::DATA_W-1:0]     data_o,
  output logic [pls_pkg::DATA_W-1:0]     pick_o
);
  import pls_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic              above, here;

  assign above = index_i > ctrl_i.at;
  assign here  = index_i == ctrl_i.at;

  // next word of this entry
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      if (above) begin
        data_d = left_i;
      end else if (here) begin
        data_d = ctrl_i.word;
      end
    end else if (ctrl_i.shift_down) begin
      if (above || here) begin
        data_d = right_i;
      end
    end
  end

  // entry storage, no reset: never read above the count
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign pick_o = (ctrl_i.pick && here) ? data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/pls_gather.sv -----
// ----------------------------------------------------------------------------
// pls_gather: collects the removed word from the cell chain
// Registered OR tree: groups of cells reduced into one register each, then
// the group registers are merged into one word.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_gather (
  input  wire logic                       clk_i,
  input  wire logic [pls_pkg::DATA_W-1:0] pick_i [pls_pkg::CAPACITY],
  output logic [pls_pkg::DATA_W-1:0]      word_o
);
  import pls_pkg::*;

  logic [DATA_W-1:0] group_q [NUM_GROUPS];
  logic [DATA_W-1:0] group_d [NUM_GROUPS];

  // first level: or within each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_d[g] = group_d[g] | pick_i[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_q[g] <= group_d[g];
    end
  end

  // second level: or across group registers
  always_comb begin
    word_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      word_o = word_o | group_q[g];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/positional_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_list_store: fixed-capacity ordered list in a chain of cells
// Each request is registered at accept, shifts the cell chain in the execute
// state, and its removed word passes the two-level registered gather; the
// result strobe is then high for one cycle. A new request is taken only when
// idle. Reset clears the count and control; cell contents are not cleared
// and need no clearing pass. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire pls_pkg::req_t   req_i,
  output logic                 done_o,
  output pls_pkg::rsp_t        rsp_o
);
  import pls_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;
  logic              ins_q, ins_d;
  logic              rem_q, rem_d;
  logic [IDX_W-1:0]  at_q, at_d;
  logic [DATA_W-1:0] word_q;
  rsp_t              rsp_q;
  logic              done_q;
  logic              accept;

  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_pick [CAPACITY];
  logic [DATA_W-1:0] gathered;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, at_ext;

  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && !busy_o;

  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(count_q);

  // request decode and status at accept
  always_comb begin
    status_d = ST_OK;
    ins_d    = 1'b0;
    rem_d    = 1'b0;
    count_d  = count_q;
    at_ext   = '0;
    case (req_i.req_type)
      REQ_INS_POS, REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (req_i.req_type == REQ_INS_POS) begin
          at_ext = pos_ext;
        end else if (req_i.req_type == REQ_INS_TAIL) begin
          at_ext = cnt_ext;
        end
        if (count_q == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else if (at_ext > cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          ins_d   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_REM_POS, REQ_REM_HEAD, REQ_REM_TAIL: begin
        if (req_i.req_type == REQ_REM_POS) begin
          at_ext = pos_ext;
        end else if (req_i.req_type == REQ_REM_TAIL) begin
          at_ext = cnt_ext - CMP_W'(1);
        end
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (at_ext >= cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          rem_d   = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    at_d = at_ext[IDX_W-1:0];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_MERGE;
      S_MERGE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ins_q   <= 1'b0;
      rem_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == S_MERGE;
      if (accept) begin
        count_q <= count_d;
        ins_q   <= ins_d;
        rem_q   <= rem_d;
      end
    end
  end

  // request payload and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      at_q     <= at_d;
      word_q   <= req_i.entry_data;
    end
    if (state_q == S_MERGE) begin
      rsp_q.removed_data <= gathered;
      rsp_q.status       <= status_q;
      rsp_q.count_after  <= COUNT_OUT_W'(count_q);
    end
  end

  // broadcast to the chain during the execute cycle
  always_comb begin
    ctrl.shift_up   = (state_q == S_EXEC) && ins_q;
    ctrl.shift_down = (state_q == S_EXEC) && rem_q;
    ctrl.pick       = (state_q == S_EXEC) && rem_q;
    ctrl.at         = at_q;
    ctrl.word       = word_q;
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .index_i (IDX_W'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .pick_o  (cell_pick[i])
    );
  end

  pls_gather u_gather (
    .clk_i  (clk_i),
    .pick_i (cell_pick),
    .word_o (gathered)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ----- tb/sv/positional_list_store_test.sv -----
// ----------------------------------------------------------------------------
// positional_list_store_test: self-checking bench for the positional list store
// Sends request words through the start/busy handshake and keeps its own copy
// of the list to predict every response word, which is checked field by field
// as the done strobe marks it. Covers empty and full lists, bad positions,
// unused request codes and long random traffic under varying sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_test;
  import pls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 40;
  localparam int unsigned TAIL_CYCLES = 8;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [POS_W-1:0] POS_LAST      = '1;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  // shadow copy of the list and the response words still to come
  logic [DATA_W-1:0] model_list[$];
  rsp_t              expected_rsp_q[$];

  int unsigned sender_idle_pct = 35;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  positional_list_store dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d response words outstanding", $time,
               expected_rsp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // apply one request to the shadow list and return the response word
  function automatic rsp_t predict_list_op(input req_t word);
    rsp_t        rsp;
    int unsigned cnt;
    int unsigned at;
    cnt    = model_list.size();
    rsp    = '0;
    rsp.status = ST_OK;
    case (word.req_type)
      REQ_INS_POS, REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (cnt >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          if (word.req_type == REQ_INS_POS) at = word.position;
          else if (word.req_type == REQ_INS_HEAD) at = 0;
          else at = cnt;
          if (at > cnt) rsp.status = ST_BADPOS;
          else model_list.insert(at, word.entry_data);
        end
      end
      REQ_REM_POS, REQ_REM_HEAD, REQ_REM_TAIL: begin
        if (cnt == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          if (word.req_type == REQ_REM_POS) at = word.position;
          else if (word.req_type == REQ_REM_HEAD) at = 0;
          else at = cnt - 1;
          if (at >= cnt) begin
            rsp.status = ST_BADPOS;
          end else begin
            rsp.removed_data = model_list[at];
            model_list.delete(at);
          end
        end
      end
      default: ;
    endcase
    rsp.count_after = COUNT_OUT_W'(model_list.size());
    return rsp;
  endfunction

  function automatic req_t make_word(input logic [REQ_W-1:0] kind,
                                     input logic [POS_W-1:0] pos,
                                     input logic [DATA_W-1:0] data);
    req_t w;
    w.req_type   = kind;
    w.position   = pos;
    w.entry_data = data;
    return w;
  endfunction

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("%0t: %s expected %h got %h", $time, field, want, got);
  endtask

  // check each response word against the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    if (done_o) begin
      if (expected_rsp_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("%0t: response word with none expected, expected none got %h",
                   $time, rsp_o);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.removed_data !== want.removed_data)
          note_mismatch("removed_data", want.removed_data, rsp_o.removed_data);
        if (rsp_o.status !== want.status)
          note_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_o.status));
        if (rsp_o.count_after !== want.count_after)
          note_mismatch("count_after", DATA_W'(want.count_after),
                        DATA_W'(rsp_o.count_after));
      end
    end
  end

  // send one request word, with a random gap first, and record its response
  task automatic send_word(input req_t word);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start_i <= 1'b1;
    req_i   <= word;
    do @(posedge clk_i); while (busy_o);
    expected_rsp_q.push_back(predict_list_op(word));
  endtask

  // hold the sender off until every response word has come back
  task automatic wait_results_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_rsp_q.size() != 0);
  endtask

  // empty list, bad positions, unused codes and data extremes on a short list
  task automatic test_empty_and_edges();
    send_word(make_word(REQ_REM_POS, '0, 32'h0000_0000));
    send_word(make_word(REQ_REM_POS, POS_LAST, 32'hFFFF_FFFF));
    send_word(make_word(REQ_REM_HEAD, '0, 32'h0000_0000));
    send_word(make_word(REQ_REM_TAIL, '0, 32'h0000_0000));
    send_word(make_word(REQ_INS_POS, 8'd1, 32'h1111_1111));
    send_word(make_word(REQ_INS_POS, POS_LAST, 32'h2222_2222));
    send_word(make_word(REQ_UNUSED_LO, '0, 32'hFFFF_FFFF));
    send_word(make_word(REQ_UNUSED_HI, POS_LAST, 32'hFFFF_FFFF));
    send_word(make_word(REQ_INS_POS, '0, 32'h0000_0000));
    send_word(make_word(REQ_INS_HEAD, POS_LAST, 32'hFFFF_FFFF));
    send_word(make_word(REQ_INS_TAIL, '0, 32'h8000_0001));
    // position equal to the count appends at the tail
    send_word(make_word(REQ_INS_POS, 8'd3, 32'h5A5A_5A5A));
    send_word(make_word(REQ_INS_POS, 8'd5, 32'h3333_3333));
    send_word(make_word(REQ_INS_POS, 8'd2, 32'h0123_4567));
    send_word(make_word(REQ_REM_POS, 8'd5, 32'h0000_0000));
    send_word(make_word(REQ_REM_POS, POS_LAST, 32'h0000_0000));
    send_word(make_word(REQ_REM_POS, 8'd2, 32'hFFFF_FFFF));
    send_word(make_word(REQ_UNUSED_HI, 8'd1, 32'hDEAD_BEEF));
    send_word(make_word(REQ_REM_HEAD, '0, 32'h0000_0000));
    send_word(make_word(REQ_REM_TAIL, '0, 32'h0000_0000));
    send_word(make_word(REQ_REM_POS, 8'd1, 32'h0000_0000));
    send_word(make_word(REQ_REM_POS, '0, 32'h0000_0000));
    send_word(make_word(REQ_REM_TAIL, '0, 32'h0000_0000));
  endtask

  // fill to capacity, hit the full list, then drain back to empty
  task automatic test_full_list();
    int unsigned       cnt;
    logic [REQ_W-1:0]  kind;
    logic [POS_W-1:0]  pos;
    while (model_list.size() < CAPACITY) begin
      cnt = model_list.size();
      case ($urandom_range(2))
        0:       kind = REQ_INS_POS;
        1:       kind = REQ_INS_HEAD;
        default: kind = REQ_INS_TAIL;
      endcase
      pos = (cnt > POS_LAST) ? POS_LAST : POS_W'($urandom_range(cnt));
      send_word(make_word(kind, pos, $urandom));
    end
    send_word(make_word(REQ_INS_POS, '0, $urandom));
    send_word(make_word(REQ_INS_POS, POS_LAST, $urandom));
    send_word(make_word(REQ_INS_HEAD, '0, $urandom));
    send_word(make_word(REQ_INS_TAIL, '0, $urandom));
    send_word(make_word(REQ_REM_POS, POS_LAST, $urandom));
    send_word(make_word(REQ_REM_POS, POS_LAST, $urandom));
    send_word(make_word(REQ_INS_POS, POS_LAST, $urandom));
    send_word(make_word(REQ_REM_POS, '0, $urandom));
    while (model_list.size() != 0) begin
      cnt = model_list.size();
      case ($urandom_range(2))
        0:       kind = REQ_REM_POS;
        1:       kind = REQ_REM_HEAD;
        default: kind = REQ_REM_TAIL;
      endcase
      send_word(make_word(kind, POS_W'($urandom_range(cnt - 1)), $urandom));
    end
    send_word(make_word(REQ_REM_HEAD, '0, $urandom));
  endtask

  // bursts that lean toward inserts or removals or stay balanced, mostly at legal positions
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned i;
    int unsigned insert_pct;
    int unsigned burst_left;
    int unsigned cnt;
    req_t        w;
    insert_pct = 50;
    burst_left = 0;
    for (i = 0; i < n_words; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 15);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      cnt          = model_list.size();
      w.entry_data = $urandom;
      w.position   = POS_W'($urandom_range(255));
      if ($urandom_range(99) < 10) begin
        // noise: any code, any position
        w.req_type = REQ_W'($urandom_range(7));
      end else if ($urandom_range(99) < insert_pct) begin
        case ($urandom_range(2))
          0:       w.req_type = REQ_INS_POS;
          1:       w.req_type = REQ_INS_HEAD;
          default: w.req_type = REQ_INS_TAIL;
        endcase
        if ($urandom_range(99) < 85)
          w.position = (cnt > POS_LAST) ? POS_LAST : POS_W'($urandom_range(cnt));
      end else begin
        case ($urandom_range(2))
          0:       w.req_type = REQ_REM_POS;
          1:       w.req_type = REQ_REM_HEAD;
          default: w.req_type = REQ_REM_TAIL;
        endcase
        if (cnt != 0 && $urandom_range(99) < 85)
          w.position = POS_W'($urandom_range(cnt - 1));
      end
      send_word(w);
    end
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 35;
    test_empty_and_edges();
    test_full_list();
    wait_results_drained();
    test_random_traffic(250);
    wait_results_drained();

    sender_idle_pct = 82;
    test_random_traffic(300);
    wait_results_drained();

    sender_idle_pct = 0;
    test_random_traffic(250);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
